// ===== hdl/longest_window_with_k_replacements_macros.svh =====
// Assertion macros shared by the longest-window RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef LONGEST_WINDOW_WITH_K_REPLACEMENTS_MACROS_SVH
`define LONGEST_WINDOW_WITH_K_REPLACEMENTS_MACROS_SVH
`ifndef ASSERT_OFF
// cond holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: invariant violated");
// ante in a cycle forces cons in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication violated");
// ante in a cycle forces cons in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/lwkr_pkg.sv =====
// Shared widths and control types for the longest-window block.
// No dependencies.
`timescale 1ns / 1ps

package lwkr_pkg;

  localparam int CODE_W    = 5;   // letter code field
  localparam int CFG_W     = 13;  // max_changes register
  localparam int LEN_W     = 13;  // best_length result field
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 16;

  // histogram commands issued by the window sequencer
  typedef struct packed {
    logic lookup;  // read count of the incoming letter
    logic bump;    // write back incremented count of the current letter
    logic evict;   // read count of the letter leaving the window
    logic clear;   // drop all counts at end of string
  } hist_ctl_t;

endpackage

// ===== hdl/lwkr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module lwkr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the last read word when no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/lwkr_hist.sv =====
// Letter histogram: count memory with per-entry valid bits, write forwarding
// and the deferred decrement of the evicted letter. Uses lwkr_pkg, lwkr_ram.
`timescale 1ns / 1ps
`include "longest_window_with_k_replacements_macros.svh"

module lwkr_hist import lwkr_pkg::*; #(
  parameter int ALPHABET = 26,
  parameter int CW       = 13
) (
  input  logic                        clk,
  input  logic                        rst,
  input  hist_ctl_t                   ctl,
  input  logic [$clog2(ALPHABET)-1:0] lookup_addr,
  input  logic [$clog2(ALPHABET)-1:0] cur_addr,
  input  logic [CW-1:0]               bump_val,
  input  logic [$clog2(ALPHABET)-1:0] evict_addr,
  output logic [CW-1:0]               cur_cnt
);

  localparam int AW = $clog2(ALPHABET);

  logic [ALPHABET-1:0] cnt_valid;
  logic                dec_v;
  logic [AW-1:0]       dec_addr;
  logic                dec_fwd;
  logic [CW-1:0]       dec_fwd_val;
  logic                fwd_v;
  logic [AW-1:0]       fwd_addr;
  logic [CW-1:0]       fwd_val;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [CW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [CW-1:0] ram_rdata;
  logic [CW-1:0] dec_cur;
  logic [CW-1:0] dec_val;

  lwkr_ram #(.WIDTH(CW), .DEPTH(ALPHABET)) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // count of the evicted letter; bypass the bump written while it was read
  assign dec_cur = dec_fwd ? dec_fwd_val :
                   (cnt_valid[dec_addr] ? ram_rdata : '0);
  assign dec_val = (dec_cur != '0) ? dec_cur - 1'b1 : dec_cur;

  always_comb begin
    ram_re    = ctl.lookup | ctl.evict;
    ram_raddr = ctl.evict ? evict_addr : lookup_addr;
    ram_we    = ctl.bump | dec_v;
    ram_waddr = ctl.bump ? cur_addr : dec_addr;
    ram_wdata = ctl.bump ? bump_val : dec_val;
  end

  // the lookup read may race with a decrement write of the same entry
  assign cur_cnt = (fwd_v && fwd_addr == cur_addr) ? fwd_val :
                   (cnt_valid[cur_addr] ? ram_rdata : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= '0;
      dec_v     <= 1'b0;
      fwd_v     <= 1'b0;
    end else begin
      dec_v <= ctl.evict;
      if (ctl.clear) begin
        cnt_valid <= '0;
        fwd_v     <= 1'b0;
      end else if (ctl.bump) begin
        cnt_valid[cur_addr] <= 1'b1;
        fwd_v               <= 1'b0;
      end else if (dec_v) begin
        fwd_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.evict) begin
      dec_addr    <= evict_addr;
      dec_fwd     <= ctl.bump && (evict_addr == cur_addr);
      dec_fwd_val <= bump_val;
    end
    if (dec_v) begin
      fwd_addr <= dec_addr;
      fwd_val  <= dec_val;
    end
  end

  `ASSERT_ALWAYS(one_writer, clk, rst, !(ctl.bump && dec_v))
  `ASSERT_ALWAYS(one_reader, clk, rst, !(ctl.lookup && ctl.evict))
  `ASSERT_NEXT(clear_flush, clk, rst, ctl.clear, !dec_v && !fwd_v && cnt_valid == '0)

endmodule

// ===== hdl/longest_window_with_k_replacements.sv =====
// Top level of the longest-window block: input and output stream stages,
// letter ring, window registers. Uses lwkr_pkg, lwkr_ram, lwkr_hist.
`timescale 1ns / 1ps
`include "longest_window_with_k_replacements_macros.svh"

// Letters arrive on the s_axis channel, one code per transfer, tlast on the
// final letter of a string. Codes of ALPHABET and above are ignored; letters
// past MAX_LEN in one string are dropped and flag overflow.
// One result per string leaves on m_axis: best_length and overflow, taken
// from the letters accepted up to and including the tlast transfer.
// max_changes is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while idle, which the block does not enforce. s_axis_tready
// drops after each transfer until the letter has left the input stage, so
// no new letter is taken before the last is through. The count memory sets
// this: the letter's count is read as it is taken, then written back while
// the evicted letter's count is read; that decrement is written in the
// following cycle. A result waits in the output register while m_axis stalls;
// letters of the next string keep flowing; only a second tlast holds until
// it is taken. Reset clears all window state at once through per-entry valid
// bits on the counts (no clearing pass); the letter ring needs no reset.
module longest_window_with_k_replacements import lwkr_pkg::*; #(
  parameter int MAX_LEN  = 4096,
  parameter int ALPHABET = 26
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [4:0] letter
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata    // [12:0] best_length, [13] overflow
);

  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int RW = $clog2(MAX_LEN);
  localparam int AW = $clog2(ALPHABET);
  localparam int SW = ((PW > CFG_W) ? PW : CFG_W) + 1;

  logic [CFG_W-1:0] max_changes;
  logic [PW-1:0]    left;
  logic [PW-1:0]    right;
  logic [PW-1:0]    top;
  logic [PW-1:0]    best;
  logic             dropped;

  logic              s1_valid;
  logic [CODE_W-1:0] s1_code;
  logic              s1_last;
  logic              s1_ok;

  logic             out_valid;
  logic [LEN_W-1:0] out_best;
  logic             out_overflow;

  logic [CODE_W-1:0] in_code;
  logic              in_ok;
  logic              accept;
  logic              s1_go;
  logic              room;
  logic              take;
  logic [CODE_W-1:0] ring_rd;
  logic [PW-1:0]     cur_cnt;
  logic [PW-1:0]     new_cnt;
  logic [PW-1:0]     top_next;
  logic [PW-1:0]     window;
  logic              shrink;
  logic [PW-1:0]     win_final;
  logic [PW-1:0]     best_next;
  logic              dropped_next;
  hist_ctl_t         hctl;

  assign in_code       = s_axis_tdata[CODE_W-1:0];
  assign in_ok         = 32'(in_code) < ALPHABET;
  assign s_axis_tready = !s1_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign room          = 32'(right) < MAX_LEN;

  // hold a final letter until the output register is free
  assign s1_go = s1_valid && !(s1_last && out_valid && !m_axis_tready);

  lwkr_ram #(.WIDTH(CODE_W), .DEPTH(MAX_LEN)) u_ring (
    .clk   (clk),
    .we    (accept && in_ok && room),
    .waddr (right[RW-1:0]),
    .wdata (in_code),
    .re    (accept),
    .raddr (left[RW-1:0]),
    .rdata (ring_rd)
  );

  always_comb begin
    take      = s1_ok && room;
    new_cnt   = cur_cnt + 1'b1;
    top_next  = (new_cnt > top) ? new_cnt : top;
    window    = right - left + 1'b1;
    shrink    = take && (left < right) &&
                (SW'(window) > SW'(top_next) + SW'(max_changes));
    win_final = shrink ? window - 1'b1 : window;
    best_next = (take && win_final > best) ? win_final : best;
    dropped_next = dropped | (s1_ok && !room);
  end

  always_comb begin
    hctl.lookup = accept && in_ok;
    hctl.bump   = s1_go && take;
    hctl.evict  = s1_go && shrink && !s1_last;
    hctl.clear  = s1_go && s1_last;
  end

  lwkr_hist #(.ALPHABET(ALPHABET), .CW(PW)) u_hist (
    .clk         (clk),
    .rst         (rst),
    .ctl         (hctl),
    .lookup_addr (AW'(in_code)),
    .cur_addr    (AW'(s1_code)),
    .bump_val    (new_cnt),
    .evict_addr  (AW'(ring_rd)),
    .cur_cnt     (cur_cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_changes <= '0;
      s1_valid    <= 1'b0;
      left        <= '0;
      right       <= '0;
      top         <= '0;
      best        <= '0;
      dropped     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_changes <= cfg_wr_data;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        if (s1_last) begin
          left    <= '0;
          right   <= '0;
          top     <= '0;
          best    <= '0;
          dropped <= 1'b0;
        end else begin
          dropped <= dropped_next;
          if (take) begin
            top   <= top_next;
            best  <= best_next;
            right <= right + 1'b1;
            if (shrink) begin
              left <= left + 1'b1;
            end
          end
        end
      end
      if (s1_go && s1_last) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_code <= in_code;
      s1_last <= s_axis_tlast;
      s1_ok   <= in_ok;
    end
    if (s1_go && s1_last) begin
      out_best     <= LEN_W'(best_next);
      out_overflow <= dropped_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(M_TDATA_W - LEN_W - 1){1'b0}}, out_overflow, out_best};

  `ASSERT_ALWAYS(edge_order, clk, rst, left <= right)
  `ASSERT_ALWAYS(pos_bound, clk, rst, 32'(right) <= MAX_LEN)
  `ASSERT_ALWAYS(freq_bound, clk, rst, top <= right - left)
  `ASSERT_NEXT(clear_after_last, clk, rst, s1_go && s1_last, right == '0 && m_axis_tvalid)

endmodule
